// ===== hw/rtl/pdfm_pkg.sv =====
// Shared constants and types of the PWM duty and frequency meter.
package pdfm_pkg;

	localparam int COUNTER_WIDTH = 16;
	localparam int CAPTURE_WIDTH = 16;
	localparam int TICK_WIDTH    = 32;
	localparam int DUTY_WIDTH    = 7;
	localparam int PROD_WIDTH    = COUNTER_WIDTH + DUTY_WIDTH;
	localparam int STEP_WIDTH    = 6;

	localparam logic [DUTY_WIDTH-1:0] PERCENT_SCALE   = DUTY_WIDTH'(100);
	localparam logic [1:0]            LAST_EDGE       = 2'd2;
	localparam logic [TICK_WIDTH-1:0] TICK_RATE_RESET = TICK_WIDTH'(250000);
	localparam logic [STEP_WIDTH-1:0] DUTY_STEPS      = STEP_WIDTH'(DUTY_WIDTH);
	localparam logic [STEP_WIDTH-1:0] FREQ_STEPS      = STEP_WIDTH'(TICK_WIDTH);
	localparam logic [STEP_WIDTH-1:0] STEP_ONE        = STEP_WIDTH'(1);

	typedef logic [COUNTER_WIDTH-1:0] cnt_t;

	typedef struct packed {
		logic                  start;
		logic [STEP_WIDTH-1:0] steps;
		cnt_t                  rem_init;
		logic [TICK_WIDTH-1:0] numer;
		cnt_t                  divisor;
	} div_cmd_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [TICK_WIDTH-1:0] quotient;
	} div_sts_t;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_MUL    = 6'b000010,
		S_DSTART = 6'b000100,
		S_DUTY   = 6'b001000,
		S_FSTART = 6'b010000,
		S_FREQ   = 6'b100000
	} state_t;

endpackage

// ===== hw/rtl/pdfm_if.sv =====
// Valid/ready channel interfaces for capture items and measurement items.
interface pdfm_in_if;
	logic                                valid;
	logic                                ready;
	logic [pdfm_pkg::CAPTURE_WIDTH-1:0] capture_time;

	modport source (output valid, output capture_time, input ready);
	modport sink   (input valid, input capture_time, output ready);
endinterface

interface pdfm_out_if;
	logic                             valid;
	logic                             ready;
	logic [pdfm_pkg::DUTY_WIDTH-1:0] duty_percent;
	logic [pdfm_pkg::TICK_WIDTH-1:0] frequency_hz;
	logic                             period_zero;

	modport source (output valid, output duty_percent, output frequency_hz,
		output period_zero, input ready);
	modport sink   (input valid, input duty_percent, input frequency_hz,
		input period_zero, output ready);
endinterface

// ===== hw/rtl/pdfm_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module pdfm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pdfm_pkg::div_cmd_t cmd,
	output pdfm_pkg::div_sts_t sts
);

	pdfm_pkg::cnt_t                            rem_q;
	pdfm_pkg::cnt_t                            divisor_q;
	logic [pdfm_pkg::TICK_WIDTH-1:0]           num_q;
	logic [pdfm_pkg::TICK_WIDTH-1:0]           quo_q;
	logic [pdfm_pkg::STEP_WIDTH-1:0]           cnt_q;
	logic                                      busy_q;
	logic                                      done_q;

	logic [pdfm_pkg::COUNTER_WIDTH:0] trial;
	logic [pdfm_pkg::COUNTER_WIDTH:0] div_ext;
	logic [pdfm_pkg::COUNTER_WIDTH:0] diff;
	logic                             ge;

	assign trial   = {rem_q, num_q[pdfm_pkg::TICK_WIDTH-1]};
	assign div_ext = {1'b0, divisor_q};
	assign diff    = trial - div_ext;
	assign ge      = trial >= div_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= cmd.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - pdfm_pkg::STEP_ONE;
				if (cnt_q == pdfm_pkg::STEP_ONE) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start && !busy_q) begin
			rem_q     <= cmd.rem_init;
			num_q     <= cmd.numer;
			divisor_q <= cmd.divisor;
			quo_q     <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[pdfm_pkg::COUNTER_WIDTH-1:0]
				: trial[pdfm_pkg::COUNTER_WIDTH-1:0];
			num_q <= {num_q[pdfm_pkg::TICK_WIDTH-2:0], 1'b0};
			quo_q <= {quo_q[pdfm_pkg::TICK_WIDTH-2:0], ge};
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = quo_q;

endmodule

// ===== hw/rtl/pwm_duty_frequency_meter_unit.sv =====
// Top level of the PWM duty and frequency meter.
//
// Feed the capture channel with counter timestamps of the measured signal in the
// order rising, falling, rising. The first two items of a group only load the
// timestamp registers. The third one produces a single measurement item (duty
// in whole percent saturated at 100, tick rate over period in hertz, and a flag
// for a zero period): it is captured, the times-100 product is formed, then the
// shared one-bit-per-cycle divider runs 7 steps for the duty and 32 steps for
// the frequency, each after a start state; a zero period skips both divisions
// and a saturated duty skips the first. The capture side is ready only while
// the sequencer is idle, so it stalls while a finished item waits for the
// output register. Write tick_rate through cfg_wr_en/cfg_wr_data only while idle.
module pwm_duty_frequency_meter_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [pdfm_pkg::TICK_WIDTH-1:0] cfg_wr_data,
	pdfm_in_if.sink                          capture,
	pdfm_out_if.source                       result
);

	pdfm_pkg::state_t                 state_q, state_d;
	logic [pdfm_pkg::TICK_WIDTH-1:0]  tick_rate_q;
	logic [1:0]                       edge_cnt_q;
	pdfm_pkg::cnt_t                   first_q, second_q;
	pdfm_pkg::cnt_t                   high_q, period_q;
	logic [pdfm_pkg::PROD_WIDTH-1:0]  prod_q;
	logic [pdfm_pkg::DUTY_WIDTH-1:0]  duty_q;
	logic                             sat_q;
	logic                             cap_ready;

	logic                             out_valid_q;
	logic [pdfm_pkg::DUTY_WIDTH-1:0]  out_duty_q;
	logic [pdfm_pkg::TICK_WIDTH-1:0]  out_freq_q;
	logic                             out_zero_q;

	logic [31:0]                      cap_ext;
	pdfm_pkg::cnt_t                   cap_t;
	logic                             accept;
	logic                             out_free;
	logic                             load_out;
	logic [pdfm_pkg::DUTY_WIDTH-1:0]  load_duty;
	logic [pdfm_pkg::TICK_WIDTH-1:0]  load_freq;
	logic                             load_zero;

	pdfm_pkg::div_cmd_t               div_cmd;
	pdfm_pkg::div_sts_t               div_sts;

	assign cap_ext  = 32'(capture.capture_time);
	assign cap_t    = cap_ext[pdfm_pkg::COUNTER_WIDTH-1:0];
	assign accept   = capture.valid && capture.ready;
	assign out_free = !out_valid_q || result.ready;

	// The sequencer may only finish when the output register can take the item.
	assign cap_ready = (state_q == pdfm_pkg::S_IDLE);
	assign capture.ready = cap_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= pdfm_pkg::TICK_RATE_RESET;
		end else if (cfg_wr_en) begin
			tick_rate_q <= cfg_wr_data;
		end
	end

	pdfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.sts    (div_sts)
	);

	always_comb begin
		div_cmd.start    = (state_q == pdfm_pkg::S_DSTART)
			|| (state_q == pdfm_pkg::S_FSTART);
		div_cmd.divisor  = period_q;
		if (state_q == pdfm_pkg::S_DSTART) begin
			div_cmd.steps    = pdfm_pkg::DUTY_STEPS;
			// high < period here, so the upper product bits stay below the divisor
			div_cmd.rem_init = prod_q[pdfm_pkg::PROD_WIDTH-1:pdfm_pkg::DUTY_WIDTH];
			div_cmd.numer    = {prod_q[pdfm_pkg::DUTY_WIDTH-1:0],
				(pdfm_pkg::TICK_WIDTH-pdfm_pkg::DUTY_WIDTH)'(0)};
		end else begin
			div_cmd.steps    = pdfm_pkg::FREQ_STEPS;
			div_cmd.rem_init = '0;
			div_cmd.numer    = tick_rate_q;
		end
	end

	always_comb begin
		state_d   = state_q;
		load_out  = 1'b0;
		load_duty = '0;
		load_freq = '0;
		load_zero = 1'b0;
		unique case (state_q)
			pdfm_pkg::S_IDLE: begin
				if (accept && edge_cnt_q == pdfm_pkg::LAST_EDGE) begin
					state_d = pdfm_pkg::S_MUL;
				end
			end
			pdfm_pkg::S_MUL: begin
				if (period_q == '0) begin
					// zero period: flag and force zero results
					if (out_free) begin
						load_out  = 1'b1;
						load_zero = 1'b1;
						state_d   = pdfm_pkg::S_IDLE;
					end
				end else if (high_q >= period_q) begin
					state_d = pdfm_pkg::S_FSTART;
				end else begin
					state_d = pdfm_pkg::S_DSTART;
				end
			end
			pdfm_pkg::S_DSTART: begin
				state_d = pdfm_pkg::S_DUTY;
			end
			pdfm_pkg::S_DUTY: begin
				if (div_sts.done) begin
					state_d = pdfm_pkg::S_FSTART;
				end
			end
			pdfm_pkg::S_FSTART: begin
				state_d = pdfm_pkg::S_FREQ;
			end
			pdfm_pkg::S_FREQ: begin
				// hold the final quotient until the output register frees up
				if ((div_sts.done || !div_sts.busy) && out_free) begin
					load_out  = 1'b1;
					load_duty = sat_q ? pdfm_pkg::PERCENT_SCALE : duty_q;
					load_freq = div_sts.quotient;
					state_d   = pdfm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pdfm_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pdfm_pkg::S_IDLE;
			edge_cnt_q  <= '0;
			first_q     <= '0;
			second_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				unique case (edge_cnt_q)
					2'd0: begin
						first_q    <= cap_t;
						edge_cnt_q <= 2'd1;
					end
					2'd1: begin
						second_q   <= cap_t;
						edge_cnt_q <= pdfm_pkg::LAST_EDGE;
					end
					default: begin
						edge_cnt_q <= '0;
					end
				endcase
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && edge_cnt_q == pdfm_pkg::LAST_EDGE) begin
			high_q   <= second_q - first_q;
			period_q <= cap_t - first_q;
		end
		if (state_q == pdfm_pkg::S_MUL) begin
			prod_q <= pdfm_pkg::PROD_WIDTH'(high_q)
				* pdfm_pkg::PROD_WIDTH'(pdfm_pkg::PERCENT_SCALE);
			sat_q  <= high_q >= period_q;
		end
		if (state_q == pdfm_pkg::S_DUTY && div_sts.done) begin
			duty_q <= div_sts.quotient[pdfm_pkg::DUTY_WIDTH-1:0];
		end
		if (load_out) begin
			out_duty_q <= load_duty;
			out_freq_q <= load_freq;
			out_zero_q <= load_zero;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.duty_percent = out_duty_q;
	assign result.frequency_hz = out_freq_q;
	assign result.period_zero  = out_zero_q;

	a_div_done_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		div_sts.done |-> (state_q == pdfm_pkg::S_DUTY || state_q == pdfm_pkg::S_FREQ))
		else $error("divider finished outside a division state");

	a_edge_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		edge_cnt_q != 2'd3)
		else $error("edge count out of range");

	a_zero_results: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.period_zero |->
		result.duty_percent == '0 && result.frequency_hz == '0)
		else $error("zero period item carries nonzero results");

	a_duty_limit: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.duty_percent <= pdfm_pkg::PERCENT_SCALE)
		else $error("duty above full scale");

	a_item_from_run: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> (state_q == pdfm_pkg::S_MUL || state_q == pdfm_pkg::S_FREQ))
		else $error("item produced outside a finishing state");

endmodule

// ===== verif/pwm_duty_frequency_meter_unit_tb.sv =====
// Self-checking testbench for the PWM duty and frequency meter top level.
`timescale 1ns / 1ps

module pwm_duty_frequency_meter_unit_tb;

	localparam int          PCT_FULL            = 100;
	localparam int          SETTLE_CYCLES       = 64;
	localparam int          RANDOM_ITEMS        = 636;
	localparam int          MISMATCH_PRINT_MAX  = 10;
	localparam int unsigned TIMEOUT_NS          = 5_000_000;

	typedef enum logic [1:0] {
		WAIT_RISE,
		WAIT_FALL,
		WAIT_NEXT_RISE
	} edge_phase_t;

	typedef struct packed {
		logic [pdfm_pkg::DUTY_WIDTH-1:0] duty;
		logic [pdfm_pkg::TICK_WIDTH-1:0] freq;
		logic                            zero;
	} meas_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_wr_en;
	logic [pdfm_pkg::TICK_WIDTH-1:0] cfg_wr_data;

	pdfm_in_if  cap_if ();
	pdfm_out_if res_if ();

	pwm_duty_frequency_meter_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.capture     (cap_if.sink),
		.result      (res_if.source)
	);

	// Meter model state
	logic [pdfm_pkg::TICK_WIDTH-1:0] tick_rate;
	pdfm_pkg::cnt_t                  rise_stamp;
	pdfm_pkg::cnt_t                  fall_stamp;
	edge_phase_t                     edge_phase;
	meas_t                           pending_meas[$];

	int unsigned send_idle_pct = 35;
	int unsigned recv_idle_pct = 50;
	int unsigned mismatch_count = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Verification failed");
		$finish;
	end

	function automatic void predict_capture(input pdfm_pkg::cnt_t stamp);
		pdfm_pkg::cnt_t high_ticks;
		pdfm_pkg::cnt_t period_ticks;
		int             ratio;
		meas_t          m;
		case (edge_phase)
			WAIT_RISE: begin
				rise_stamp = stamp;
				edge_phase = WAIT_FALL;
			end
			WAIT_FALL: begin
				fall_stamp = stamp;
				edge_phase = WAIT_NEXT_RISE;
			end
			default: begin
				edge_phase   = WAIT_RISE;
				high_ticks   = fall_stamp - rise_stamp;
				period_ticks = stamp - rise_stamp;
				if (period_ticks == '0) begin
					m.duty = '0;
					m.freq = '0;
					m.zero = 1'b1;
				end else begin
					ratio = (int'(high_ticks) * PCT_FULL) / int'(period_ticks);
					if (ratio > PCT_FULL)
						ratio = PCT_FULL;
					m.duty = pdfm_pkg::DUTY_WIDTH'(ratio);
					m.freq = tick_rate / pdfm_pkg::TICK_WIDTH'(period_ticks);
					m.zero = 1'b0;
				end
				pending_meas.push_back(m);
			end
		endcase
	endfunction

	task automatic note_mismatch(input string what, input meas_t want, input meas_t got);
		mismatch_count++;
		if (mismatch_count <= MISMATCH_PRINT_MAX)
			$display("%0t: %s: expected duty=%0d freq=%0d zero=%0b, got duty=%0d freq=%0d zero=%0b",
				$realtime, what, want.duty, want.freq, want.zero, got.duty, got.freq, got.zero);
	endtask

	// Measurement checker and output back-pressure
	always @(posedge clk) begin : meas_check
		meas_t want;
		meas_t got;
		if (arst_n && res_if.valid && res_if.ready) begin
			got.duty = res_if.duty_percent;
			got.freq = res_if.frequency_hz;
			got.zero = res_if.period_zero;
			if (pending_meas.size() == 0) begin
				note_mismatch("unexpected measurement", '0, got);
			end else begin
				want = pending_meas.pop_front();
				if (got.duty !== want.duty || got.freq !== want.freq || got.zero !== want.zero)
					note_mismatch("measurement mismatch", want, got);
			end
		end
		res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_capture(input pdfm_pkg::cnt_t stamp);
		while ($urandom_range(99) < send_idle_pct) begin
			cap_if.valid <= 1'b0;
			@(posedge clk);
		end
		cap_if.valid        <= 1'b1;
		cap_if.capture_time <= stamp;
		@(posedge clk);
		while (!cap_if.ready)
			@(posedge clk);
		predict_capture(stamp);
	endtask

	task automatic send_group(input pdfm_pkg::cnt_t rise, input pdfm_pkg::cnt_t high_ticks,
			input pdfm_pkg::cnt_t period_ticks);
		send_capture(rise);
		send_capture(rise + high_ticks);
		send_capture(rise + period_ticks);
	endtask

	// Drain all measurements, then let the divider finish any trailing work
	task automatic wait_for_measurements();
		cap_if.valid <= 1'b0;
		while (pending_meas.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_tick_rate(input logic [pdfm_pkg::TICK_WIDTH-1:0] rate);
		wait_for_measurements();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= rate;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		tick_rate = rate;
		@(posedge clk);
	endtask

	task automatic send_random_group();
		int unsigned    pick;
		pdfm_pkg::cnt_t rise;
		pdfm_pkg::cnt_t high_ticks;
		pdfm_pkg::cnt_t period_ticks;
		pick = $urandom_range(99);
		rise = pdfm_pkg::cnt_t'($urandom);
		if (pick < 45) begin
			// realistic pulse train, mostly short periods
			if ($urandom_range(3) == 0)
				period_ticks = pdfm_pkg::cnt_t'($urandom_range(65535, 1));
			else
				period_ticks = pdfm_pkg::cnt_t'($urandom_range(4000, 1));
			high_ticks = pdfm_pkg::cnt_t'($urandom_range(int'(period_ticks), 0));
			send_group(rise, high_ticks, period_ticks);
		end else if (pick < 65) begin
			period_ticks = pdfm_pkg::cnt_t'($urandom_range(64, 1));
			high_ticks   = pdfm_pkg::cnt_t'($urandom_range(int'(period_ticks), 0));
			send_group(rise, high_ticks, period_ticks);
		end else if (pick < 75) begin
			// out-of-order edges: high time beyond the period
			period_ticks = pdfm_pkg::cnt_t'($urandom_range(65534, 1));
			high_ticks   = pdfm_pkg::cnt_t'($urandom_range(65535, int'(period_ticks) + 1));
			send_group(rise, high_ticks, period_ticks);
		end else if (pick < 82) begin
			send_group(rise, pdfm_pkg::cnt_t'($urandom), '0);
		end else begin
			send_capture(rise);
			send_capture(pdfm_pkg::cnt_t'($urandom));
			send_capture(pdfm_pkg::cnt_t'($urandom));
		end
	endtask

	task automatic test_directed_edges();
		send_group(16'h0000, 16'h0000, 16'h0000);
		send_group(16'h0007, 16'h005D, 16'h0000);
		send_group(16'h0000, 16'h7FFF, 16'hFFFF);
		send_group(16'h0000, 16'hFFFF, 16'hFFFF);
		send_group(16'hFFFF, 16'h0001, 16'h0002);
		send_group(16'h0064, 16'h0064, 16'h0032);
		send_group(16'h0000, 16'h0000, 16'h0001);
		send_group(16'h000A, 16'h0000, 16'h000A);
		wait_for_measurements();
	endtask

	task automatic test_tick_rate_extremes();
		load_tick_rate(32'h0000_0001);
		send_group(16'h1234, 16'h0000, 16'h0001);
		send_group(16'hAAAA, 16'h0001, 16'h0002);
		send_group(16'h5555, 16'h0000, 16'h0000);
		load_tick_rate(32'hFFFF_FFFF);
		send_group(16'h8000, 16'h0001, 16'h0001);
		send_group(16'h0000, 16'h8000, 16'hFFFF);
		send_group(16'hFFF0, 16'h0003, 16'h0007);
		load_tick_rate(pdfm_pkg::TICK_RATE_RESET);
		send_group(16'h0100, 16'h0040, 16'h00FA);
	endtask

	task automatic test_random_captures(input int unsigned sender_idle,
			input int unsigned receiver_idle);
		int sent;
		load_tick_rate(pdfm_pkg::TICK_WIDTH'($urandom_range(32'hFFFF_FFFF, 1)));
		send_idle_pct = sender_idle;
		recv_idle_pct = receiver_idle;
		for (sent = 0; sent < RANDOM_ITEMS; sent += 3)
			send_random_group();
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_wr_en           = 1'b0;
		cfg_wr_data         = '0;
		cap_if.valid        = 1'b0;
		cap_if.capture_time = '0;
		tick_rate           = pdfm_pkg::TICK_RATE_RESET;
		rise_stamp          = '0;
		fall_stamp          = '0;
		edge_phase          = WAIT_RISE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_tick_rate_extremes();
		test_random_captures(35, 50);
		test_random_captures(50, 35);
		test_random_captures(0, 0);
		wait_for_measurements();

		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
